/* rtl/mbr_pkg.sv */
// Shared types and constants of the MSB-first bit reader with exp-Golomb decoding.
`default_nettype none

package mbr_pkg;

   localparam int STORE_BYTES_DEFAULT   = 1024;
   localparam int MAX_READ_BITS_DEFAULT = 24;
   localparam int LEN_BITS              = 11;
   localparam int WINDOW_BITS           = 32;

   typedef enum logic [2:0] {
      OP_RESTART    = 3'd0,
      OP_LOAD_BYTE  = 3'd1,
      OP_READ_BITS  = 3'd2,
      OP_READ_UE    = 3'd3,
      OP_READ_BYTES = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TAKE,
      ST_BYTES
   } state_type;

   // What the current bit fetch is for.
   typedef enum logic [2:0] {
      USE_BITS,
      USE_PREFIX,
      USE_SUFFIX,
      USE_BYTE,
      USE_PART
   } use_type;

   typedef struct packed {
      logic [WINDOW_BITS-1:0] value;
      logic                   last;
      logic                   error;
      logic                   at_end;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/mbr_ifs.sv */
// Valid/ready channel interfaces for requests, responses and the length register.
`default_nettype none

interface mbr_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [9:0] address;
   logic [7:0] data_byte;
   logic [8:0] count;

   modport source (output valid, output operation, output address, output data_byte,
                   output count, input ready);
   modport sink (input valid, input operation, input address, input data_byte,
                 input count, output ready);
endinterface

interface mbr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mbr_pkg::WINDOW_BITS-1:0] value;
   logic                            last;
   logic                            error;
   logic                            at_end;

   modport source (output valid, output value, output last, output error, output at_end,
                   input ready);
   modport sink (input valid, input value, input last, input error, input at_end,
                 output ready);
endinterface

interface mbr_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mbr_pkg::LEN_BITS-1:0] buffer_length;

   modport source (output valid, output buffer_length, input ready);
   modport sink (input valid, input buffer_length, output ready);
endinterface

`default_nettype wire

/* rtl/mbr_store.sv */
// Byte store: single-port write, registered read.
`default_nettype none

module mbr_store #(
   parameter int STORE_BYTES = mbr_pkg::STORE_BYTES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(STORE_BYTES)-1:0] wr_addr,
   input  wire logic [7:0]                     wr_data,
   input  wire logic [$clog2(STORE_BYTES)-1:0] rd_addr,
   output logic      [7:0]                     rd_data
);

   logic [7:0] store_ff [STORE_BYTES];
   logic [7:0] rd_data_ff;

   // Read before write: a read of the entry being written returns the old byte.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/mbr_rsp_reg.sv */
// Response output register that decouples the sequencer from a stalling receiver.
`default_nettype none

module mbr_rsp_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mbr_pkg::rsp_type push_data,
   output logic                  slot_free,
   mbr_rsp_if.source             rsp_bus
);

   logic             valid_ff;
   logic             valid_in;
   mbr_pkg::rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_bus.valid  = valid_ff;
   assign rsp_bus.value  = data_ff.value;
   assign rsp_bus.last   = data_ff.last;
   assign rsp_bus.error  = data_ff.error;
   assign rsp_bus.at_end = data_ff.at_end;

endmodule

`default_nettype wire

/* rtl/mbr_engine.sv */
// Read sequencer: positions, bit window, byte store accesses and ue(v) decoding.
`default_nettype none

module mbr_engine #(
   parameter int STORE_BYTES   = mbr_pkg::STORE_BYTES_DEFAULT,
   parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   mbr_req_if.sink                             req_bus,
   mbr_csr_if.sink                             csr_bus,
   output logic                                store_wr_en,
   output logic      [$clog2(STORE_BYTES)-1:0] store_wr_addr,
   output logic      [7:0]                     store_wr_data,
   output logic      [$clog2(STORE_BYTES)-1:0] store_rd_addr,
   input  wire logic [7:0]                     store_rd_data,
   output logic                                push,
   output mbr_pkg::rsp_type                    push_data,
   input  wire logic                           slot_free
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam int PW = $clog2(STORE_BYTES + 1);

   mbr_pkg::state_type state_ff, state_in;
   mbr_pkg::use_type   use_ff, use_in;
   logic [4:0]                 n_ff, n_in;
   logic [4:0]                 zeros_ff, zeros_in;
   logic                       acc_err_ff, acc_err_in;
   logic [5:0]                 whole_ff, whole_in;
   logic [2:0]                 part_ff, part_in;
   logic                       direct_ff, direct_in;
   logic [PW-1:0]              bytepos_ff, bytepos_in;
   logic [5:0]                 bitpos_ff, bitpos_in;
   logic [31:0]                window_ff, window_in;
   logic                       end_ff, end_in;
   logic                       started_ff, started_in;
   logic [mbr_pkg::LEN_BITS-1:0] len_ff, len_in;

   logic        req_go;
   logic        restart_go;
   logic [5:0]  avail;
   logic [4:0]  shift;
   logic        pos_ok;
   logic        t_none, t_bad, t_short, t_adv, t_eof, t_err;
   logic        refill, t_done, end_after;
   logic [31:0] t_value;
   logic [31:0] ue_base;
   logic [7:0]  part_byte;
   logic        emit_req;
   logic        hold;

   assign req_bus.ready = (state_ff == mbr_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_go        = req_bus.valid && req_bus.ready;
   assign restart_go    = req_go && (req_bus.operation == mbr_pkg::OP_RESTART);

   // Store port: loads write directly; the read follows the next byte position so the
   // registered read data always holds the byte at the current position. A load never
   // overlaps a read that is used: any read request is taken in a later cycle.
   assign store_wr_en   = req_go && (req_bus.operation == mbr_pkg::OP_LOAD_BYTE)
                          && (32'(req_bus.address) < STORE_BYTES);
   assign store_wr_addr = AW'(req_bus.address);
   assign store_wr_data = req_bus.data_byte;
   assign store_rd_addr = bytepos_in[AW-1:0];

   assign pos_ok = (32'(bytepos_ff) < 32'(len_ff)) && (32'(bytepos_ff) < STORE_BYTES);

   // One step of a bit fetch of n_ff bits.
   always_comb begin
      avail   = 6'd32 - bitpos_ff;
      shift   = 5'(avail - 6'(n_ff));
      t_none  = (n_ff == 5'd0);
      t_bad   = !started_ff || (32'(n_ff) > MAX_READ_BITS) || end_ff;
      t_short = (6'(n_ff) > avail);
      t_adv   = !t_none && !t_bad && !t_short;
      refill  = (state_ff == mbr_pkg::ST_TAKE) && !t_none && !t_bad && t_short && pos_ok;
      t_done  = (state_ff == mbr_pkg::ST_TAKE) && !refill;
      // The end is reached only when a refill is needed and no byte is left.
      t_eof   = !t_none && !t_bad && t_short && !pos_ok;
      t_err   = !t_none && (t_bad || t_short);
      t_value = t_adv ? ((window_ff >> shift) & ((32'd1 << n_ff) - 32'd1)) : 32'd0;
      end_after = end_ff || t_eof;
      ue_base   = (32'd1 << zeros_ff) - 32'd1;
      part_byte = 8'(t_value[7:0] << (4'd8 - {1'b0, part_ff}));
   end

   // Result emission.
   always_comb begin
      emit_req  = 1'b0;
      push_data = '0;
      unique case (state_ff)
         mbr_pkg::ST_IDLE: begin
         end
         mbr_pkg::ST_TAKE: begin
            if (t_done) begin
               unique case (use_ff)
                  mbr_pkg::USE_BITS: begin
                     emit_req  = 1'b1;
                     push_data = '{t_value, 1'b1, acc_err_ff | t_err, end_after};
                  end
                  mbr_pkg::USE_PREFIX: begin
                     // Thirty-two zeros in a row saturate the code.
                     if (!t_value[0] && !end_after && (zeros_ff == 5'd31)) begin
                        emit_req  = 1'b1;
                        push_data = '{32'hFFFF_FFFF, 1'b1, 1'b1, end_after};
                     end
                  end
                  mbr_pkg::USE_SUFFIX: begin
                     emit_req  = 1'b1;
                     push_data = '{ue_base + t_value, 1'b1, acc_err_ff | t_err, end_after};
                  end
                  mbr_pkg::USE_BYTE: begin
                     emit_req  = 1'b1;
                     push_data = '{t_value, (whole_ff == 6'd1) && (part_ff == 3'd0),
                                   t_err, end_after};
                  end
                  mbr_pkg::USE_PART: begin
                     emit_req  = 1'b1;
                     push_data = '{{24'd0, part_byte}, 1'b1, t_err, end_after};
                  end
                  default: begin
                  end
               endcase
            end
         end
         mbr_pkg::ST_BYTES: begin
            if ((whole_ff != 6'd0) && direct_ff) begin
               emit_req  = 1'b1;
               push_data = '{pos_ok ? {24'd0, store_rd_data} : 32'd0,
                             (whole_ff == 6'd1) && (part_ff == 3'd0),
                             !pos_ok, end_ff || !pos_ok};
            end
         end
         default: begin
         end
      endcase
   end

   assign hold = emit_req && !slot_free;
   assign push = emit_req && slot_free;

   // Next state and register updates.
   always_comb begin
      state_in   = state_ff;
      use_in     = use_ff;
      n_in       = n_ff;
      zeros_in   = zeros_ff;
      acc_err_in = acc_err_ff;
      whole_in   = whole_ff;
      part_in    = part_ff;
      direct_in  = direct_ff;
      bytepos_in = bytepos_ff;
      bitpos_in  = bitpos_ff;
      window_in  = window_ff;
      end_in     = end_ff;
      started_in = started_ff;
      len_in     = csr_bus.valid ? csr_bus.buffer_length : len_ff;

      if (!hold) begin
         unique case (state_ff)
            mbr_pkg::ST_IDLE: begin
               if (req_go) begin
                  unique case (mbr_pkg::op_type'(req_bus.operation))
                     mbr_pkg::OP_RESTART: begin
                        bytepos_in = '0;
                        bitpos_in  = 6'd32;
                        window_in  = 32'd0;
                        end_in     = 1'b0;
                        started_in = 1'b1;
                     end
                     mbr_pkg::OP_LOAD_BYTE: begin
                     end
                     mbr_pkg::OP_READ_BITS: begin
                        state_in = mbr_pkg::ST_TAKE;
                        use_in   = mbr_pkg::USE_BITS;
                        // A bad size fetches nothing and reports the error.
                        if ((req_bus.count == 9'd0) ||
                            (32'(req_bus.count) > MAX_READ_BITS)) begin
                           n_in       = 5'd0;
                           acc_err_in = 1'b1;
                        end else begin
                           n_in       = req_bus.count[4:0];
                           acc_err_in = 1'b0;
                        end
                     end
                     mbr_pkg::OP_READ_UE: begin
                        state_in   = mbr_pkg::ST_TAKE;
                        use_in     = mbr_pkg::USE_PREFIX;
                        n_in       = 5'd1;
                        zeros_in   = 5'd0;
                        acc_err_in = 1'b0;
                     end
                     mbr_pkg::OP_READ_BYTES: begin
                        if (req_bus.count != 9'd0) begin
                           state_in  = mbr_pkg::ST_BYTES;
                           whole_in  = req_bus.count[8:3];
                           part_in   = req_bus.count[2:0];
                           direct_in = (bitpos_ff == 6'd32);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            mbr_pkg::ST_TAKE: begin
               if (refill) begin
                  window_in  = {window_ff[23:0], store_rd_data};
                  bitpos_in  = bitpos_ff - 6'd8;
                  bytepos_in = bytepos_ff + PW'(1);
               end
               if (t_eof) begin
                  end_in = 1'b1;
               end
               if (t_adv) begin
                  bitpos_in = bitpos_ff + 6'(n_ff);
               end
               if (t_done) begin
                  unique case (use_ff)
                     mbr_pkg::USE_BITS: begin
                        state_in = mbr_pkg::ST_IDLE;
                     end
                     mbr_pkg::USE_PREFIX: begin
                        acc_err_in = acc_err_ff | t_err;
                        if (t_value[0] || end_after) begin
                           use_in = mbr_pkg::USE_SUFFIX;
                           n_in   = zeros_ff;
                        end else if (zeros_ff == 5'd31) begin
                           state_in = mbr_pkg::ST_IDLE;
                        end else begin
                           zeros_in = zeros_ff + 5'd1;
                        end
                     end
                     mbr_pkg::USE_SUFFIX: begin
                        state_in = mbr_pkg::ST_IDLE;
                     end
                     mbr_pkg::USE_BYTE: begin
                        whole_in = whole_ff - 6'd1;
                        state_in = mbr_pkg::ST_BYTES;
                     end
                     mbr_pkg::USE_PART: begin
                        state_in = mbr_pkg::ST_IDLE;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            mbr_pkg::ST_BYTES: begin
               if (whole_ff != 6'd0) begin
                  if (direct_ff) begin
                     if (pos_ok) begin
                        bytepos_in = bytepos_ff + PW'(1);
                     end else begin
                        end_in = 1'b1;
                     end
                     whole_in = whole_ff - 6'd1;
                     if ((whole_ff == 6'd1) && (part_ff == 3'd0)) begin
                        state_in = mbr_pkg::ST_IDLE;
                     end
                  end else begin
                     state_in = mbr_pkg::ST_TAKE;
                     use_in   = mbr_pkg::USE_BYTE;
                     n_in     = 5'd8;
                  end
               end else if (part_ff != 3'd0) begin
                  state_in = mbr_pkg::ST_TAKE;
                  use_in   = mbr_pkg::USE_PART;
                  n_in     = {2'd0, part_ff};
               end else begin
                  state_in = mbr_pkg::ST_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mbr_pkg::ST_IDLE;
         bytepos_ff <= '0;
         bitpos_ff  <= 6'd0;
         window_ff  <= 32'd0;
         end_ff     <= 1'b0;
         started_ff <= 1'b0;
         len_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         bytepos_ff <= bytepos_in;
         bitpos_ff  <= bitpos_in;
         window_ff  <= window_in;
         end_ff     <= end_in;
         started_ff <= started_in;
         len_ff     <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      use_ff     <= use_in;
      n_ff       <= n_in;
      zeros_ff   <= zeros_in;
      acc_err_ff <= acc_err_in;
      whole_ff   <= whole_in;
      part_ff    <= part_in;
      direct_ff  <= direct_in;
   end

   a_push_slot: assert property (@(posedge clock) disable iff (reset) push |-> slot_free)
      else $error("response pushed into an occupied output register");

   a_bitpos_range: assert property (@(posedge clock) disable iff (reset)
      bitpos_ff <= 6'd32)
      else $error("bit position beyond the window");

   a_bytepos_range: assert property (@(posedge clock) disable iff (reset)
      32'(bytepos_ff) <= STORE_BYTES)
      else $error("byte position beyond the store");

   a_refill_stays: assert property (@(posedge clock) disable iff (reset)
      refill |=> (state_ff == mbr_pkg::ST_TAKE))
      else $error("fetch left before its refill was used");

   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(end_ff) |-> $past(restart_go || reset))
      else $error("end of buffer flag cleared without a restart");

endmodule

`default_nettype wire

/* rtl/msb_bit_reader_exp_golomb.sv */
// Top level of the MSB-first bit reader with exp-Golomb ue(v) decoding.
//
// Requests arrive on req_bus: restart, load byte, read bits, read ue(v) and read
// bytes. Restart, load byte and a zero-byte read give no response. Other reads give
// their responses on rsp_bus, the final one marked by last. csr_bus writes the byte
// store length and is always ready; write it only while no read is in progress.
//
// The sequencer works on one request at a time and refills the 32-bit window one
// byte per cycle from the byte store. Read bits refills the window as needed, then
// takes the bits. ue(v) takes the prefix bit by bit up to and including the closing
// one, then the suffix (none after 32 zeros), refilling as needed. Read bytes passes
// whole bytes straight from the store when the window is empty, otherwise takes each
// byte through the window with refills; a partial byte then goes through the window.
//
// Responses pass through one output register, so the next request is accepted
// while a response waits; the sequencer stalls only when it has a new response
// and the register is still full. Reset is synchronous: it clears the positions,
// the flags and the length, but not the byte store, which is undefined until
// loaded.
`default_nettype none

module msb_bit_reader_exp_golomb #(
   parameter int STORE_BYTES   = mbr_pkg::STORE_BYTES_DEFAULT,
   parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   mbr_req_if.sink    req_bus,
   mbr_rsp_if.source  rsp_bus,
   mbr_csr_if.sink    csr_bus
);

   localparam int AW = $clog2(STORE_BYTES);

   logic             store_wr_en;
   logic [AW-1:0]    store_wr_addr;
   logic [7:0]       store_wr_data;
   logic [AW-1:0]    store_rd_addr;
   logic [7:0]       store_rd_data;
   logic             push;
   mbr_pkg::rsp_type push_data;
   logic             slot_free;

   // The sequencer owns all reader state apart from the bytes themselves.
   mbr_engine #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_READ_BITS (MAX_READ_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .csr_bus       (csr_bus),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .push          (push),
      .push_data     (push_data),
      .slot_free     (slot_free)
   );

   // The byte store is a synchronous memory.
   mbr_store #(
      .STORE_BYTES (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // The output register holds one response while the receiver stalls.
   mbr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .slot_free (slot_free),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
